// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the queue depth, the operation codes and the entry and control types.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } spq_kind_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] rank;
  } spq_entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

// File: sv/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if: valid-ready channels of the sorted priority queue
// One interface for operation items, one for result items.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic [0:0]                          kind;
  logic signed [spq_pkg::DATA_W-1:0]   item_value;
  logic signed [spq_pkg::DATA_W-1:0]   item_rank;

  modport source (output valid, kind, item_value, item_rank, input ready);
  modport sink   (input valid, kind, item_value, item_rank, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spq_pkg::DATA_W-1:0]   head_value;
  logic signed [spq_pkg::DATA_W-1:0]   head_rank;
  logic                                head_valid;
  logic                                underflow;
  logic                                overflow;
  logic [spq_pkg::CNT_W-1:0]           fill_level;

  modport source (output valid, head_value, head_rank, head_valid, underflow,
                  overflow, fill_level, input ready);
  modport sink   (input valid, head_value, head_rank, head_valid, underflow,
                  overflow, fill_level, output ready);
endinterface

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Keeps its entry, takes the new entry, or shifts from a neighbour.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::spq_ctrl_t  ctrl_i,
  input  spq_pkg::spq_entry_t new_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  input  logic                left_stay_i,
  input  logic                occupied_i,
  output logic                stay_o,
  output spq_pkg::spq_entry_t entry_o
);

  spq_pkg::spq_entry_t entry_q, entry_d;

  // ties stay ahead of the new entry
  assign stay_o = occupied_i && (entry_q.rank <= new_i.rank);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.deq) begin
      entry_d = right_i;
    end else if (ctrl_i.enq && !stay_o) begin
      entry_d = left_stay_i ? new_i : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue, lowest rank served first
// A row of slot cells kept in ascending rank order; equal ranks leave in
// arrival order. Enqueue on full flags overflow, dequeue on empty underflow.
//
//   channel  dir  payload                                        items
//   in_i     in   kind, item_value, item_rank                    operations
//   out_o    out  head_value, head_rank, head_valid, underflow,  one per op
//                 overflow, fill_level
//
// one item per cycle while results are taken: every cell decides locally in the accepting cycle
// the result is captured in the output register in the cycle after acceptance
// in_i.ready falls only while a result waits and out_o.ready is low
// reset empties the queue at once; slot contents need no clearing
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  spq_in_if.sink       in_i,
  spq_out_if.source    out_o
);

  localparam int unsigned Depth = spq_pkg::QUEUE_DEPTH;

  logic [spq_pkg::CNT_W-1:0] count_q, count_d;
  logic                      out_valid_q;
  spq_pkg::spq_entry_t       head_q;
  logic                      head_valid_q, underflow_q, overflow_q;

  logic                      acc, is_deq, full, empty;
  spq_pkg::spq_ctrl_t        ctrl;
  spq_pkg::spq_entry_t       new_entry;
  spq_pkg::spq_entry_t       cell_entry [Depth];
  logic                      cell_stay  [Depth];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign is_deq     = (in_i.kind == spq_pkg::KIND_DEQ);
  assign full       = (count_q == spq_pkg::CNT_W'(Depth));
  assign empty      = (count_q == '0);

  assign ctrl.enq = acc && !is_deq && !full;
  assign ctrl.deq = acc && is_deq && !empty;

  assign new_entry.value = in_i.item_value;
  assign new_entry.rank  = in_i.item_rank;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::spq_entry_t left, right;
    logic                left_stay;

    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_stay = 1'b1;
    end else begin : g_mid
      assign left      = cell_entry[i-1];
      assign left_stay = cell_stay[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .left_i      (left),
      .right_i     (right),
      .left_stay_i (left_stay),
      .occupied_i  (spq_pkg::CNT_W'(i) < count_q),
      .stay_o      (cell_stay[i]),
      .entry_o     (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + spq_pkg::CNT_W'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - spq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      head_q       <= ctrl.deq ? cell_entry[0] : '0;
      head_valid_q <= ctrl.deq;
      underflow_q  <= is_deq && empty;
      overflow_q   <= !is_deq && full;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.head_value = head_q.value;
  assign out_o.head_rank  = head_q.rank;
  assign out_o.head_valid = head_valid_q;
  assign out_o.underflow  = underflow_q;
  assign out_o.overflow   = overflow_q;
  assign out_o.fill_level = count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CNT_W'(Depth))
    else $error("entry count beyond depth");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($countones({out_o.head_valid, out_o.underflow,
                                 out_o.overflow}) <= 1))
    else $error("result flags not exclusive");

  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq |=> (count_q == $past(count_q) - spq_pkg::CNT_W'(1)))
    else $error("dequeue did not lower the count");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_deq && full) |=> (count_q == $past(count_q) && out_o.overflow))
    else $error("enqueue on full changed the queue");

endmodule
